>>> rtl/core/otsc_pkg.sv
// ----------------------------------------------------------------------------
// otsc_pkg - shared types and helpers for the scratchpad check
// Holds the CRC-8 step, the resolution decode, byte positions and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package otsc_pkg;

    // Reflected CRC-8 polynomial (LSB first)
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Byte positions inside a scratchpad frame
    localparam logic [3:0] IDX_TEMP_LO = 4'd0;
    localparam logic [3:0] IDX_TEMP_HI = 4'd1;
    localparam logic [3:0] IDX_CONFIG  = 4'd4;
    localparam logic [3:0] IDX_CRC     = 4'd8;
    localparam logic [3:0] IDX_IDLE    = 4'd9;

    // Known config byte codes
    localparam logic [7:0] CFG_RES9  = 8'h1F;
    localparam logic [7:0] CFG_RES10 = 8'h3F;
    localparam logic [7:0] CFG_RES11 = 8'h5F;
    localparam logic [7:0] CFG_RES12 = 8'h7F;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_CRC_MISMATCH = 2'd1,
        ST_BAD_CONFIG   = 2'd2
    } t_check_status;

    // One input byte with its frame marker
    typedef struct packed {
        logic [7:0] scratch_byte;
        logic       frame_start;
    } t_byte_item;

    // Handshake between input stage and frame stage
    typedef struct packed {
        logic       valid;
        t_byte_item item;
    } t_stage_fwd;

    // One byte through the CRC, eight bit steps unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ data[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Config byte to resolution in bits, 0 for unknown codes
    function automatic logic [3:0] decode_resolution(input logic [7:0] cfg);
        logic [3:0] res;
        case (cfg)
            CFG_RES9:  res = 4'd9;
            CFG_RES10: res = 4'd10;
            CFG_RES11: res = 4'd11;
            CFG_RES12: res = 4'd12;
            default:   res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/otsc_if.sv
// ----------------------------------------------------------------------------
// otsc_if - stream channels of the scratchpad check
// Byte channel in, result channel out; valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface otsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scratch_byte;
    logic       frame_start;

    modport source (output valid, output scratch_byte, output frame_start, input ready);
    modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

interface otsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temp_raw;
    logic        [3:0]  resolution_bits;
    logic        [7:0]  crc_value;
    logic        [1:0]  check_status;

    modport source (output valid, output temp_raw, output resolution_bits,
                    output crc_value, output check_status, input ready);
    modport sink   (input valid, input temp_raw, input resolution_bits,
                    input crc_value, input check_status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/otsc_in_stage.sv
// ----------------------------------------------------------------------------
// otsc_in_stage - input register
// Captures one byte transfer; releases it when the frame stage advances.
// ----------------------------------------------------------------------------
`default_nettype none

module otsc_in_stage
    import otsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_byte_item i_item,
    output logic            o_ready,
    input  wire logic       i_advance,
    output t_stage_fwd      o_fwd
);

    logic       r_valid;
    t_byte_item r_item;

    // room when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_fwd.valid = r_valid;
    assign o_fwd.item  = r_item;

endmodule

`default_nettype wire

>>> rtl/core/otsc_frame.sv
// ----------------------------------------------------------------------------
// otsc_frame - frame state and result register
// Runs the CRC, tracks byte position, keeps bytes 0, 1 and 4, and loads the
// result register on byte 8.
// ----------------------------------------------------------------------------
`default_nettype none

module otsc_frame
    import otsc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_stage_fwd   i_fwd,
    output logic              o_advance,
    otsc_result_if.source     o_result
);

    logic [7:0]    r_crc, n_crc;
    logic [3:0]    r_byte_index, n_byte_index;
    logic [7:0]    r_temp_lo, n_temp_lo;
    logic [7:0]    r_temp_hi, n_temp_hi;
    logic [7:0]    r_config, n_config;

    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_temp_raw, n_temp_raw;
    logic [3:0]    r_res, n_res;
    logic [7:0]    r_crc_out, n_crc_out;
    t_check_status r_status, n_status;

    logic [3:0]    idx;
    logic [7:0]    crc_base;
    logic [3:0]    res_dec;
    logic [7:0]    b;

    // move on when the result register is empty or being drained
    assign o_advance = !r_out_valid || o_result.ready;

    // next state for one byte
    always_comb begin
        b            = i_fwd.item.scratch_byte;
        idx          = i_fwd.item.frame_start ? IDX_TEMP_LO : r_byte_index;
        crc_base     = i_fwd.item.frame_start ? 8'h00 : r_crc;
        res_dec      = decode_resolution(r_config);

        n_crc        = r_crc;
        n_byte_index = r_byte_index;
        n_temp_lo    = r_temp_lo;
        n_temp_hi    = r_temp_hi;
        n_config     = r_config;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_temp_raw   = r_temp_raw;
        n_res        = r_res;
        n_crc_out    = r_crc_out;
        n_status     = r_status;

        if (i_fwd.valid && o_advance) begin
            n_crc = crc_base;
            if (idx < IDX_CRC) begin
                // data byte: fold into CRC, keep the ones we report
                n_crc        = crc8_byte(crc_base, b);
                n_byte_index = idx + 4'd1;
                if (idx == IDX_TEMP_LO) begin
                    n_temp_lo = b;
                end else if (idx == IDX_TEMP_HI) begin
                    n_temp_hi = b;
                end else if (idx == IDX_CONFIG) begin
                    n_config = b;
                end
            end else if (idx == IDX_CRC) begin
                // check byte: build result, mismatch wins over bad config
                n_byte_index = IDX_IDLE;
                n_out_valid  = 1'b1;
                n_temp_raw   = {r_temp_hi, r_temp_lo};
                n_res        = res_dec;
                n_crc_out    = crc_base;
                if (crc_base != b) begin
                    n_status = ST_CRC_MISMATCH;
                end else if (res_dec == 4'd0) begin
                    n_status = ST_BAD_CONFIG;
                end else begin
                    n_status = ST_OK;
                end
            end else begin
                // trailing bytes are dropped
                n_byte_index = IDX_IDLE;
            end
        end
    end

    // control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_crc        <= 8'h00;
            r_byte_index <= IDX_TEMP_LO;
            r_temp_lo    <= 8'h00;
            r_temp_hi    <= 8'h00;
            r_config     <= 8'h00;
        end else begin
            r_out_valid  <= n_out_valid;
            r_crc        <= n_crc;
            r_byte_index <= n_byte_index;
            r_temp_lo    <= n_temp_lo;
            r_temp_hi    <= n_temp_hi;
            r_config     <= n_config;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_temp_raw <= n_temp_raw;
        r_res      <= n_res;
        r_crc_out  <= n_crc_out;
        r_status   <= n_status;
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.temp_raw        = $signed(r_temp_raw);
    assign o_result.resolution_bits = r_res;
    assign o_result.crc_value       = r_crc_out;
    assign o_result.check_status    = r_status;

endmodule

`default_nettype wire

>>> rtl/core/onewire_temp_scratchpad_check.sv
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_check - sensor scratchpad CRC and decode
// Takes nine scratchpad bytes, checks the CRC-8, reports temperature,
// resolution, computed CRC and a status.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload                                        Transfer
//  i_byte     in   scratch_byte[7:0], frame_start                 valid & ready
//  o_result   out  temp_raw[15:0] s, resolution_bits[3:0],        valid & ready
//                  crc_value[7:0], check_status[1:0]
//
//  One byte per cycle sustained while the result is not stalled; byte 8
//  goes through the input register, then the frame/result register, which
//  loads the result. Throughput is set by the unrolled CRC byte update.
//  Synchronous active-low reset clears valids, CRC and byte position.
//  A stalled result holds the pipeline; the input register still takes one
//  more byte while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_temp_scratchpad_check
    import otsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    otsc_byte_if.sink     i_byte,
    otsc_result_if.source o_result
);

    t_byte_item in_item;
    t_stage_fwd fwd;
    logic       advance;

    assign in_item.scratch_byte = i_byte.scratch_byte;
    assign in_item.frame_start  = i_byte.frame_start;

    // input register
    otsc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .i_item    (in_item),
        .o_ready   (i_byte.ready),
        .i_advance (advance),
        .o_fwd     (fwd)
    );

    // frame state and result register
    otsc_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fwd     (fwd),
        .o_advance (advance),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/otsc_checker.sv
// ----------------------------------------------------------------------------
// otsc_checker - port-level checks for the scratchpad check
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module otsc_checker
    import otsc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_temp_raw,
    input wire logic [3:0]  i_resolution_bits,
    input wire logic [7:0]  i_crc_value,
    input wire logic [1:0]  i_check_status
);

    // stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_temp_raw) && $stable(i_resolution_bits)
            && $stable(i_crc_value) && $stable(i_check_status))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // resolution is one of the decoded values
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_resolution_bits == 4'd0 || i_resolution_bits == 4'd9
            || i_resolution_bits == 4'd10 || i_resolution_bits == 4'd11
            || i_resolution_bits == 4'd12))
        else $error("bad resolution");

    // status agrees with the decoded resolution
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_check_status == ST_CRC_MISMATCH
            || (i_check_status == ST_OK && i_resolution_bits != 4'd0)
            || (i_check_status == ST_BAD_CONFIG && i_resolution_bits == 4'd0)))
        else $error("status inconsistent with resolution");

endmodule

bind onewire_temp_scratchpad_check otsc_checker u_otsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_temp_raw        (o_result.temp_raw),
    .i_resolution_bits (o_result.resolution_bits),
    .i_crc_value       (o_result.crc_value),
    .i_check_status    (o_result.check_status)
);

`default_nettype wire
